// ===== rtl/core/bppc_pkg.sv =====
// shared types, codes and helpers of the branch profile predictor counter
`default_nettype none

package bppc_pkg;

   localparam int BLOCK_W = 12;
   localparam int COUNT_W = 32;
   localparam int PRED_W  = 2;

   typedef enum logic [1:0] {
      KIND_INCREMENT = 2'd0,
      KIND_ENTER     = 2'd1,
      KIND_LEAVE     = 2'd2,
      KIND_READ      = 2'd3
   } kind_type;

   // 2-bit predictor levels
   localparam logic [PRED_W-1:0] PRED_STRONG_NOT = 2'd0;
   localparam logic [PRED_W-1:0] PRED_WEAK_NOT   = 2'd1;
   localparam logic [PRED_W-1:0] PRED_WEAK_TAKEN = 2'd2;
   localparam logic [PRED_W-1:0] PRED_STRONG_TAKEN = 2'd3;

   typedef struct packed {
      logic [COUNT_W-1:0] exec_count;
      logic [COUNT_W-1:0] taken_count;
      logic [COUNT_W-1:0] mispredict_count;
      logic [PRED_W-1:0]  predictor_state;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // saturating increment, all ones stays all ones
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bppc_if.sv =====
// valid/ready channel interfaces for profile events and entry reads
`default_nettype none

interface bppc_req_if
   import bppc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   kind_type            kind;
   logic [BLOCK_W-1:0]  block_index;

   modport source (output valid, kind, block_index, input ready);
   modport sink   (input valid, kind, block_index, output ready);
endinterface

interface bppc_rsp_if
   import bppc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  exec_count;
   logic [COUNT_W-1:0]  taken_count;
   logic [COUNT_W-1:0]  mispredict_count;
   logic [PRED_W-1:0]   predictor_state;

   modport source (output valid, exec_count, taken_count, mispredict_count,
                   predictor_state, input ready);
   modport sink   (input valid, exec_count, taken_count, mispredict_count,
                   predictor_state, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bppc_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module bppc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/branch_profile_predictor_counter_core.sv =====
// branch profiling table with per-block 2-bit branch predictor simulation
//
// usage
//   req_chan carries profile beats: kind (increment, enter, leave, read) and
//   block_index. rsp_chan returns one beat per read: the three saturating
//   counters and the predictor state of the entry. csr_wr_en/csr_wr_data
//   set predictor_enable; write it only while the block is idle.
// flow
//   all table state sits in one single-port-read ram, one entry per block;
//   beats are handled one at a time, in-range increment and enter as a
//   read-modify-write of it. leave and out-of-range increment or enter beats
//   stay in ST_IDLE; increment, read and an enter with no pending leave pass
//   ST_MODIFY; an enter after a leave passes ST_MODIFY, ST_ISSUE, ST_MODIFY
//   (branch update of the left block, then the entered block's count).
// reset
//   reset starts a clearing pass that zeroes the table one entry a cycle;
//   req_chan.ready stays low until the pass has cleared every entry.
// back-pressure
//   the result sits in an output register; a stalled rsp_chan holds it and
//   the block keeps taking beats until a second read result needs the slot.
`default_nettype none

module branch_profile_predictor_counter_core
   import bppc_pkg::*;
#(
   parameter int NUM_BLOCKS = 4096
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bppc_req_if.sink    req_chan,
   bppc_rsp_if.source  rsp_chan,
   input  wire logic   csr_wr_en,
   input  wire logic   csr_wr_data
);

   localparam int AW = $clog2(NUM_BLOCKS);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_MODIFY = 4'b0100,
      ST_ISSUE  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   kind_type              kind_ff, kind_in;
   logic [AW-1:0]         blk_ff, blk_in;
   logic                  ok_ff, ok_in;
   logic                  branch_step_ff, branch_step_in;
   logic                  taken_ff, taken_in;
   logic [BLOCK_W-1:0]    left_block_ff, left_block_in;
   logic                  left_valid_ff, left_valid_in;
   logic                  pred_en_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   entry_type             rsp_entry_ff, rsp_entry_in;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   entry_type             ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   entry_type             ram_rd_data;

   logic                  req_fire;
   logic                  req_ok;
   logic [AW+BLOCK_W-1:0] req_addr_ext;
   logic [AW+BLOCK_W-1:0] left_addr_ext;
   logic [AW-1:0]         req_addr;
   logic [AW-1:0]         left_addr;
   logic                  req_taken;
   entry_type             branch_entry;
   entry_type             exec_entry;
   logic [PRED_W-1:0]     pred_cur;

   // table ram: {exec, taken, mispredict, predictor} per block
   bppc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // indexes at or above NUM_BLOCKS touch nothing
   assign req_ok = {20'd0, req_chan.block_index} < 32'(NUM_BLOCKS);

   assign req_addr_ext  = {{AW{1'b0}}, req_chan.block_index};
   assign left_addr_ext = {{AW{1'b0}}, left_block_ff};
   assign req_addr  = req_addr_ext[AW-1:0];
   assign left_addr = left_addr_ext[AW-1:0];

   // fall-through is left block plus one, formed without wrap
   assign req_taken = {1'b0, req_chan.block_index} != ({1'b0, left_block_ff} + 1'b1);

   // branch update of the left block
   assign pred_cur = ram_rd_data.predictor_state;
   always_comb begin
      branch_entry = ram_rd_data;
      if (taken_ff) begin
         branch_entry.taken_count = sat_inc(ram_rd_data.taken_count);
      end
      if (pred_en_ff) begin
         if (taken_ff) begin
            if (pred_cur == PRED_STRONG_NOT || pred_cur == PRED_WEAK_NOT) begin
               branch_entry.mispredict_count = sat_inc(ram_rd_data.mispredict_count);
            end
            if (pred_cur != PRED_STRONG_TAKEN) begin
               branch_entry.predictor_state = pred_cur + 1'b1;
            end
         end else begin
            if (pred_cur == PRED_WEAK_TAKEN || pred_cur == PRED_STRONG_TAKEN) begin
               branch_entry.mispredict_count = sat_inc(ram_rd_data.mispredict_count);
            end
            if (pred_cur != PRED_STRONG_NOT) begin
               branch_entry.predictor_state = pred_cur - 1'b1;
            end
         end
      end
   end

   always_comb begin
      exec_entry = ram_rd_data;
      exec_entry.exec_count = sat_inc(ram_rd_data.exec_count);
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      kind_in        = kind_ff;
      blk_in         = blk_ff;
      ok_in          = ok_ff;
      branch_step_in = branch_step_ff;
      taken_in       = taken_ff;
      left_block_in  = left_block_ff;
      left_valid_in  = left_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_entry_in   = rsp_entry_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = blk_ff;
      ram_wr_data    = exec_entry;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = req_addr;

      // output beat taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(NUM_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               kind_in = req_chan.kind;
               blk_in  = req_addr;
               ok_in   = req_ok;
               unique case (req_chan.kind)
                  KIND_INCREMENT: begin
                     if (req_ok) begin
                        ram_rd_en      = 1'b1;
                        branch_step_in = 1'b0;
                        state_in       = ST_MODIFY;
                     end
                  end
                  KIND_ENTER: begin
                     if (req_ok) begin
                        left_valid_in = 1'b0;
                        taken_in      = req_taken;
                        ram_rd_en     = 1'b1;
                        state_in      = ST_MODIFY;
                        // pending leave: update the left block first
                        if (left_valid_ff) begin
                           ram_rd_addr    = left_addr;
                           branch_step_in = 1'b1;
                        end else begin
                           branch_step_in = 1'b0;
                        end
                     end
                  end
                  KIND_LEAVE: begin
                     if (req_ok) begin
                        left_block_in = req_chan.block_index;
                        left_valid_in = 1'b1;
                     end
                  end
                  KIND_READ: begin
                     ram_rd_en      = req_ok;
                     branch_step_in = 1'b0;
                     state_in       = ST_MODIFY;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            if (kind_ff == KIND_READ) begin
               // wait for a free output slot; ram read data holds meanwhile
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_entry_in = ok_ff ? ram_rd_data : '0;
                  state_in     = ST_IDLE;
               end
            end else if (branch_step_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = left_addr;
               ram_wr_data = branch_entry;
               state_in    = ST_ISSUE;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = blk_ff;
               ram_wr_data = exec_entry;
               state_in    = ST_IDLE;
            end
         end
         ST_ISSUE: begin
            // entered block read after the branch write has landed
            ram_rd_en      = 1'b1;
            ram_rd_addr    = blk_ff;
            branch_step_in = 1'b0;
            state_in       = ST_MODIFY;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         branch_step_ff <= 1'b0;
         left_block_ff  <= '0;
         left_valid_ff  <= 1'b0;
         pred_en_ff     <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         branch_step_ff <= branch_step_in;
         left_block_ff  <= left_block_in;
         left_valid_ff  <= left_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            pred_en_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      blk_ff       <= blk_in;
      ok_ff        <= ok_in;
      taken_ff     <= taken_in;
      rsp_entry_ff <= rsp_entry_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.exec_count       = rsp_entry_ff.exec_count;
   assign rsp_chan.taken_count      = rsp_entry_ff.taken_count;
   assign rsp_chan.mispredict_count = rsp_entry_ff.mispredict_count;
   assign rsp_chan.predictor_state  = rsp_entry_ff.predictor_state;

endmodule

`default_nettype wire

// ===== rtl/core/bppc_checker.sv =====
// port-level checks of the branch profile predictor counter, bound to the top level
`default_nettype none

module bppc_checker
   import bppc_pkg::*;
(
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     req_valid,
   input wire logic     req_ready,
   input wire kind_type req_kind,
   input wire logic     rsp_valid,
   input wire logic     rsp_ready
);

   // stalled result beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // table clearing pass keeps the input closed right after reset
   assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input open during clearing pass");

   // a read beat occupies the block on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_READ |=> !req_ready)
      else $error("input open while a read is in flight");

   // a fresh result beat only follows a read beat accepted before the modify state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_kind == KIND_READ, 2))
      else $error("result beat without a read");

endmodule

bind branch_profile_predictor_counter_core bppc_checker u_bppc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_kind  (req_chan.kind),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

`default_nettype wire

// ===== tb/sv/branch_profile_predictor_counter_core_test.sv =====
// self-checking regression of the branch profile predictor counter core
module branch_profile_predictor_counter_core_test;
   import bppc_pkg::*;

   localparam int NUM_BLOCKS  = 4096;
   // clearing pass plus every beat at its slowest with stalls, taken many times over
   localparam int CYCLE_LIMIT = 400000;
   // settling margin after the slowest beat (enter after leave)
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      kind_type           kind;
      logic [BLOCK_W-1:0] blk;
      bit                 typed;
      entry_type          want;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   bppc_req_if req_chan ();
   bppc_rsp_if rsp_chan ();

   branch_profile_predictor_counter_core #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the profiling table and the pending leave
   logic [COUNT_W-1:0] prof_exec  [NUM_BLOCKS];
   logic [COUNT_W-1:0] prof_taken [NUM_BLOCKS];
   logic [COUNT_W-1:0] prof_miss  [NUM_BLOCKS];
   logic [PRED_W-1:0]  prof_state [NUM_BLOCKS];
   logic [BLOCK_W-1:0] left_blk_shadow;
   bit                 left_pending;
   bit                 pred_en_shadow;

   // read results still owed by the core, oldest first
   entry_type   pending_reads [$];
   dir_row_type dir_rows [$];

   // what the beat now on the request channel expects, for typed directed rows
   bit        cur_typed;
   entry_type cur_want;

   int unsigned cycle_count;
   int unsigned beats_done;
   int unsigned reads_checked;
   int unsigned taken_total;
   int unsigned miss_total;
   int unsigned mismatches;
   bit          calm;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
      return (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   task automatic clear_profile_shadow();
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         prof_exec[i]  = '0;
         prof_taken[i] = '0;
         prof_miss[i]  = '0;
         prof_state[i] = PRED_STRONG_NOT;
      end
      left_blk_shadow = '0;
      left_pending    = 1'b0;
      pred_en_shadow  = 1'b1;
   endtask

   // apply one accepted beat to the shadow table, return the read result if any
   task automatic profile_table_update(input kind_type k, input logic [BLOCK_W-1:0] b,
                                       output bit gives, output entry_type res);
      int unsigned        idx;
      int unsigned        prev;
      bit                 had_left;
      bit                 taken;
      logic [PRED_W-1:0]  s;
      idx   = b;
      gives = 1'b0;
      res   = '0;
      case (k)
         KIND_INCREMENT: begin
            if (idx < NUM_BLOCKS) prof_exec[idx] = count_up(prof_exec[idx]);
         end
         KIND_ENTER: begin
            if (idx < NUM_BLOCKS) begin
               had_left = left_pending;
               prev     = left_blk_shadow;
               // the fall-through index is formed wider than the field, no wrap
               taken        = had_left && (idx != prev + 1);
               left_pending = 1'b0;
               prof_exec[idx] = count_up(prof_exec[idx]);
               if (had_left && prev < NUM_BLOCKS) begin
                  if (taken) begin
                     prof_taken[prev] = count_up(prof_taken[prev]);
                     taken_total++;
                  end
                  if (pred_en_shadow) begin
                     s = prof_state[prev];
                     if (taken) begin
                        if (s < PRED_WEAK_TAKEN) begin
                           prof_miss[prev] = count_up(prof_miss[prev]);
                           miss_total++;
                        end
                        if (s != PRED_STRONG_TAKEN) s = s + 1'b1;
                     end else begin
                        if (s >= PRED_WEAK_TAKEN) begin
                           prof_miss[prev] = count_up(prof_miss[prev]);
                           miss_total++;
                        end
                        if (s != PRED_STRONG_NOT) s = s - 1'b1;
                     end
                     prof_state[prev] = s;
                  end
               end
            end
         end
         KIND_LEAVE: begin
            if (idx < NUM_BLOCKS) begin
               left_blk_shadow = b;
               left_pending    = 1'b1;
            end
         end
         default: begin
            gives = 1'b1;
            if (idx < NUM_BLOCKS) begin
               res.exec_count       = prof_exec[idx];
               res.taken_count      = prof_taken[idx];
               res.mispredict_count = prof_miss[idx];
               res.predictor_state  = prof_state[idx];
            end
         end
      endcase
   endtask

   // beat monitor, scoreboard and watchdog, all sampled at the rising edge
   always @(posedge clock) begin
      entry_type got;
      entry_type exp_entry;
      entry_type res;
      bit        gives;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d reads outstanding",
                  cycle_count, pending_reads.size());
         $display("branch_profile_predictor_counter_core regression: fail");
         $finish;
      end else if (!reset) begin
         // result beat against the oldest outstanding read
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.exec_count       = rsp_chan.exec_count;
            got.taken_count      = rsp_chan.taken_count;
            got.mispredict_count = rsp_chan.mispredict_count;
            got.predictor_state  = rsp_chan.predictor_state;
            if (pending_reads.size() == 0) begin
               $error("result beat with no read outstanding");
               mismatches++;
            end else begin
               exp_entry = pending_reads.pop_front();
               reads_checked++;
               if (got.exec_count !== exp_entry.exec_count) begin
                  $error("exec_count: expected %0h, actual %0h",
                         exp_entry.exec_count, got.exec_count);
                  mismatches++;
               end
               if (got.taken_count !== exp_entry.taken_count) begin
                  $error("taken_count: expected %0h, actual %0h",
                         exp_entry.taken_count, got.taken_count);
                  mismatches++;
               end
               if (got.mispredict_count !== exp_entry.mispredict_count) begin
                  $error("mispredict_count: expected %0h, actual %0h",
                         exp_entry.mispredict_count, got.mispredict_count);
                  mismatches++;
               end
               if (got.predictor_state !== exp_entry.predictor_state) begin
                  $error("predictor_state: expected %0h, actual %0h",
                         exp_entry.predictor_state, got.predictor_state);
                  mismatches++;
               end
            end
         end
         // accepted request beat goes through the shadow table
         if (req_chan.valid && req_chan.ready) begin
            profile_table_update(req_chan.kind, req_chan.block_index, gives, res);
            if (gives) pending_reads.push_back(cur_typed ? cur_want : res);
            beats_done++;
         end
         if (csr_wr_en) pred_en_shadow = csr_wr_data;
      end
   end

   // result side back-pressure, quiet during the calm stretch
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
      end
   end

   always @(negedge clock) calm <= (beats_done >= 700 && beats_done < 900);

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 31);
   endfunction

   // starts at a falling edge, returns at the falling edge after acceptance
   task automatic send_beat(input kind_type k, input logic [BLOCK_W-1:0] b,
                            input bit typed, input entry_type want);
      if (idle_now()) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
         while (idle_now()) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.kind        <= k;
      req_chan.block_index <= b;
      cur_typed            <= typed;
      cur_want             <= want;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   // lower valid and let every read come back, then let the last beat retire
   task automatic drain_core();
      req_chan.valid <= 1'b0;
      while (pending_reads.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_predictor_enable(input bit v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic add_row(input kind_type k, input int b, input bit typed,
                          input int unsigned ex, input int unsigned tk,
                          input int unsigned ms, input logic [PRED_W-1:0] st);
      dir_row_type row;
      row.kind                  = k;
      row.blk                   = b[BLOCK_W-1:0];
      row.typed                 = typed;
      row.want.exec_count       = ex;
      row.want.taken_count      = tk;
      row.want.mispredict_count = ms;
      row.want.predictor_state  = st;
      dir_rows.push_back(row);
   endtask

   // mostly a small hot window so counters and predictors climb, some top blocks, some anywhere
   function automatic logic [BLOCK_W-1:0] pick_block();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 65) return BLOCK_W'($urandom_range(15));
      else if (r < 80) return BLOCK_W'($urandom_range(NUM_BLOCKS - 1, NUM_BLOCKS - 8));
      else return BLOCK_W'($urandom_range(NUM_BLOCKS - 1));
   endfunction

   task automatic run_random(input int n);
      int                 sent;
      int unsigned        r;
      logic [BLOCK_W-1:0] b;
      logic [BLOCK_W-1:0] e;
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(99);
         b = pick_block();
         if (r < 55) begin
            // leave then enter: fall-through, self branch or a jump
            r = $urandom_range(99);
            if (r < 45) e = b + 1'b1;
            else if (r < 70) e = b;
            else e = pick_block();
            send_beat(KIND_LEAVE, b, 1'b0, '0);
            send_beat(KIND_ENTER, e, 1'b0, '0);
            sent += 2;
         end else if (r < 68) begin
            send_beat(KIND_INCREMENT, b, 1'b0, '0);
            sent++;
         end else if (r < 92) begin
            send_beat(KIND_READ, b, 1'b0, '0);
            sent++;
         end else begin
            // broken sequences: lone leave or lone enter
            send_beat(($urandom_range(1) != 0) ? KIND_LEAVE : KIND_ENTER, b, 1'b0, '0);
            sent++;
         end
      end
   endtask

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = 1'b0;
      req_chan.valid       = 1'b0;
      req_chan.kind        = KIND_INCREMENT;
      req_chan.block_index = '0;
      cur_typed            = 1'b0;
      cur_want             = '0;
      calm                 = 1'b0;
      cycle_count          = 0;
      beats_done           = 0;
      reads_checked        = 0;
      taken_total          = 0;
      miss_total           = 0;
      mismatches           = 0;
      clear_profile_shadow();

      // table comes up cleared at both ends
      add_row(KIND_READ,      0,    1'b1, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_READ,      4095, 1'b1, 0, 0, 0, PRED_STRONG_NOT);
      // plain increment
      add_row(KIND_INCREMENT, 5,    1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_READ,      5,    1'b1, 1, 0, 0, PRED_STRONG_NOT);
      // fall-through is not taken, strong not-taken stays put
      add_row(KIND_LEAVE,     10,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_ENTER,     11,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_READ,      10,   1'b1, 0, 0, 0, PRED_STRONG_NOT);
      // last block then block 0 counts as taken, no wrap of the fall-through
      add_row(KIND_LEAVE,     4095, 1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_ENTER,     0,    1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_READ,      4095, 1'b1, 0, 1, 1, PRED_WEAK_NOT);
      add_row(KIND_READ,      0,    1'b1, 1, 0, 0, PRED_STRONG_NOT);
      // enter with no leave only counts the execution
      add_row(KIND_ENTER,     20,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_READ,      20,   1'b1, 1, 0, 0, PRED_STRONG_NOT);
      // second leave replaces the first
      add_row(KIND_LEAVE,     30,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_LEAVE,     40,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_ENTER,     41,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_READ,      40,   1'b1, 0, 0, 0, PRED_STRONG_NOT);
      // self branch hits both counters of one entry, twice to reach weak taken
      add_row(KIND_LEAVE,     50,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_ENTER,     50,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_READ,      50,   1'b1, 1, 1, 1, PRED_WEAK_NOT);
      add_row(KIND_LEAVE,     50,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_ENTER,     50,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_READ,      50,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      // enter clears the pending leave, a later enter leaves block 60 alone
      add_row(KIND_LEAVE,     60,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_ENTER,     61,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_ENTER,     70,   1'b0, 0, 0, 0, PRED_STRONG_NOT);
      add_row(KIND_READ,      60,   1'b1, 0, 0, 0, PRED_STRONG_NOT);

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // explicit write of the reset setting, the clearing pass does not care
      write_predictor_enable(1'b1);

      foreach (dir_rows[i]) send_beat(dir_rows[i].kind, dir_rows[i].blk,
                                      dir_rows[i].typed, dir_rows[i].want);
      run_random(500);
      drain_core();

      // predictor off: states and miss counts must freeze
      write_predictor_enable(1'b0);
      run_random(450);
      drain_core();

      // back on, predictors resume from their frozen states
      write_predictor_enable(1'b1);
      run_random(450);
      drain_core();
      repeat (2 * SETTLE_CYCLES) @(negedge clock);

      if (pending_reads.size() != 0) begin
         $error("%0d reads never answered", pending_reads.size());
         mismatches++;
      end
      $display("covered %0d beats, %0d read results checked, predictor on, off and on again",
               beats_done, reads_checked);
      $display("shadow table saw %0d taken branches and %0d mispredictions",
               taken_total, miss_total);
      if (mismatches == 0) begin
         $display("branch_profile_predictor_counter_core regression: pass");
      end else begin
         $display("branch_profile_predictor_counter_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== branch_profile_predictor_counter_core.f =====
rtl/core/bppc_pkg.sv
rtl/core/bppc_if.sv
rtl/core/bppc_ram.sv
rtl/core/branch_profile_predictor_counter_core.sv
rtl/core/bppc_checker.sv
tb/sv/branch_profile_predictor_counter_core_test.sv
